@@ hw/rtl/slis_pkg.sv @@
// ----------------------------------------------------------------------------
// slis_pkg
// Command and status types shared by the sorter controller and datapath.
// ----------------------------------------------------------------------------
package slis_pkg;

    typedef struct packed {
        logic insert;
        logic drop;
        logic pop;
        logic pop_last;
    } slis_cmd_t;

    typedef struct packed {
        logic full;
        logic remaining_one;
    } slis_status_t;

endpackage

@@ hw/rtl/slis_item_if.sv @@
// ----------------------------------------------------------------------------
// slis_item_if
// Valid/ready channel carrying one entry of a set into the sorter.
// ----------------------------------------------------------------------------
interface slis_item_if #(
    parameter int KEY_BITS = 8,
    parameter int TAG_BITS = 16
);
    logic                       valid;
    logic                       ready;
    logic signed [KEY_BITS-1:0] item_layer;
    logic        [TAG_BITS-1:0] item_tag;
    logic                       end_of_set;

    modport source (output valid, output item_layer, output item_tag, output end_of_set,
                    input ready);
    modport sink   (input valid, input item_layer, input item_tag, input end_of_set,
                    output ready);
endinterface

@@ hw/rtl/slis_result_if.sv @@
// ----------------------------------------------------------------------------
// slis_result_if
// Valid/ready channel carrying one sorted entry out of the sorter.
// ----------------------------------------------------------------------------
interface slis_result_if #(
    parameter int KEY_BITS = 8,
    parameter int TAG_BITS = 16
);
    logic                       valid;
    logic                       ready;
    logic signed [KEY_BITS-1:0] out_layer;
    logic        [TAG_BITS-1:0] out_tag;
    logic                       out_last;
    logic                       overflowed;

    modport source (output valid, output out_layer, output out_tag, output out_last,
                    output overflowed, input ready);
    modport sink   (input valid, input out_layer, input out_tag, input out_last,
                    input overflowed, output ready);
endinterface

@@ hw/rtl/stable_layer_insertion_sorter.sv @@
// ----------------------------------------------------------------------------
// stable_layer_insertion_sorter
// Stable insertion sort of layer/tag entries, emitted as one sorted set.
// ----------------------------------------------------------------------------
// Entries are taken one per clock while a set is being collected: every cell
// compares its key against the new one in parallel and the row shifts to open
// a slot, so equal keys keep arrival order. The entry flagged end_of_set is
// inserted in its own cycle, after which the block stops taking entries and
// drains the row from the head cell through an output register at one result
// per clock while the sink keeps up; a stalled sink holds the drain. Entries
// arriving with the row full are dropped and every result of that set carries
// overflowed. The next set may start while the last result of the previous
// one still waits in the output register.
// ----------------------------------------------------------------------------
module stable_layer_insertion_sorter
    import slis_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int KEY_BITS = 8,
    parameter int TAG_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    slis_item_if.sink    item,
    slis_result_if.source result
);

    slis_cmd_t    cmd;
    slis_status_t status;

    slis_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (item.valid),
        .end_of_set (item.end_of_set),
        .in_ready   (item.ready),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .status     (status),
        .cmd        (cmd)
    );

    slis_datapath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_layer (item.item_layer),
        .item_tag   (item.item_tag),
        .cmd        (cmd),
        .status     (status),
        .out_layer  (result.out_layer),
        .out_tag    (result.out_tag),
        .out_last   (result.out_last),
        .overflowed (result.overflowed)
    );

endmodule

@@ hw/rtl/slis_datapath.sv @@
// ----------------------------------------------------------------------------
// slis_datapath
// Row of sorted cells with parallel compare and shift insertion, fill count,
// drop flag and the output register fed from the head cell.
// ----------------------------------------------------------------------------
module slis_datapath
    import slis_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int KEY_BITS = 8,
    parameter int TAG_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic signed [KEY_BITS-1:0] item_layer,
    input  logic        [TAG_BITS-1:0] item_tag,
    input  slis_cmd_t                  cmd,
    output slis_status_t               status,
    output logic signed [KEY_BITS-1:0] out_layer,
    output logic        [TAG_BITS-1:0] out_tag,
    output logic                       out_last,
    output logic                       overflowed
);

    localparam int FILL_BITS = $clog2(CAPACITY + 1);

    logic signed [KEY_BITS-1:0] key_reg [CAPACITY];
    logic        [TAG_BITS-1:0] tag_reg [CAPACITY];
    logic        [CAPACITY-1:0] ins;
    logic        [FILL_BITS-1:0] fill_reg, fill_next;
    logic                        drop_reg, drop_next;
    logic signed [KEY_BITS-1:0] out_layer_reg;
    logic        [TAG_BITS-1:0] out_tag_reg;
    logic                       out_last_reg;
    logic                       overflowed_reg;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            // empty cells count as greater, so the entry lands at the fill point
            assign ins[g] = (fill_reg > FILL_BITS'(g)) ? (item_layer < key_reg[g]) : 1'b1;

            if (g == 0)
            begin : g_head
                always_ff @(posedge clk)
                begin
                    if (cmd.pop)
                    begin
                        if (CAPACITY > 1)
                        begin
                            key_reg[g] <= key_reg[(g + 1) % CAPACITY];
                            tag_reg[g] <= tag_reg[(g + 1) % CAPACITY];
                        end
                    end
                    else if (cmd.insert && ins[g])
                    begin
                        key_reg[g] <= item_layer;
                        tag_reg[g] <= item_tag;
                    end
                end
            end
            else
            begin : g_body
                always_ff @(posedge clk)
                begin
                    if (cmd.pop)
                    begin
                        if (g < CAPACITY - 1)
                        begin
                            key_reg[g] <= key_reg[(g + 1) % CAPACITY];
                            tag_reg[g] <= tag_reg[(g + 1) % CAPACITY];
                        end
                    end
                    else if (cmd.insert && ins[g-1])
                    begin
                        key_reg[g] <= key_reg[g-1];
                        tag_reg[g] <= tag_reg[g-1];
                    end
                    else if (cmd.insert && ins[g])
                    begin
                        key_reg[g] <= item_layer;
                        tag_reg[g] <= item_tag;
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        fill_next = fill_reg;
        drop_next = drop_reg;
        if (cmd.insert)
        begin
            fill_next = fill_reg + FILL_BITS'(1);
        end
        if (cmd.drop)
        begin
            drop_next = 1'b1;
        end
        if (cmd.pop)
        begin
            fill_next = fill_reg - FILL_BITS'(1);
        end
        if (cmd.pop_last)
        begin
            drop_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            drop_reg <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            out_layer_reg  <= key_reg[0];
            out_tag_reg    <= tag_reg[0];
            out_last_reg   <= cmd.pop_last;
            overflowed_reg <= drop_reg;
        end
    end

    assign status.full          = (fill_reg == FILL_BITS'(CAPACITY));
    assign status.remaining_one = (fill_reg == FILL_BITS'(1));

    assign out_layer  = out_layer_reg;
    assign out_tag    = out_tag_reg;
    assign out_last   = out_last_reg;
    assign overflowed = overflowed_reg;

endmodule

@@ hw/rtl/slis_controller.sv @@
// ----------------------------------------------------------------------------
// slis_controller
// Collect/emit sequencer: accepts entries, then drains the sorted cells one
// request at a time into the output register.
// ----------------------------------------------------------------------------
module slis_controller
    import slis_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         end_of_set,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  slis_status_t status,
    output slis_cmd_t    cmd
);

    typedef enum logic {
        COLLECT,
        EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   pop;

    assign in_ready = (state_reg == COLLECT);
    assign accept   = in_valid && in_ready;
    assign pop      = (state_reg == EMIT) && (!out_valid_reg || out_ready);

    assign cmd.insert   = accept && !status.full;
    assign cmd.drop     = accept && status.full;
    assign cmd.pop      = pop;
    assign cmd.pop_last = pop && status.remaining_one;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            COLLECT:
            begin
                if (accept && end_of_set)
                begin
                    state_next = EMIT;
                end
            end
            EMIT:
            begin
                if (pop && status.remaining_one)
                begin
                    state_next = COLLECT;
                end
            end
            default:
            begin
                state_next = COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= COLLECT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
